// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core.
// Synthesis builds see empty bodies; simulation builds see concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/fcd_pkg.sv =====
// Types and constants for the FAST corner detector.
// No dependencies.
package fcd_pkg;
	localparam int unsigned NPTS = 16;
	localparam int unsigned ARC = 9;
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [7:0] THRESH_RST = 8'd20;
	localparam logic [10:0] WIDTH_RST = 11'd640;
	localparam logic [10:0] HEIGHT_RST = 11'd480;
	// circle offsets into the 7x7 window, position 0 at the top, clockwise
	localparam logic [2:0] CROW [NPTS] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
		3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
	localparam logic [2:0] CCOL [NPTS] = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
		3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};

	typedef struct packed {
		logic [7:0] pixel;
		logic frame_start;
	} in_item_t;

	typedef struct packed {
		logic [9:0] center_x;
		logic [9:0] center_y;
		logic corner;
		logic [11:0] score;
		logic frame_last;
	} out_item_t;
endpackage

// ===== rtl/fast_corner_detector_core.sv =====
// FAST-9 corner detector: one pixel per clock in raster order, one result per interior pixel.
// Every accepted pixel moves through five registered stages, the last of which is the output
// register holding the result for that pixel's window. A held output freezes every stage and
// stalls the input, so throughput is one pixel per clock whenever results drain. The line memory
// does one registered read and one write per cycle. Results exist only for centres at least
// three pixels from each border. The line memory has no reset; each frame refills it during its
// first six rows, so change geometry only between frames. Depends on fcd_pkg, assert_macros.svh.
`include "assert_macros.svh"
module fast_corner_detector_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fcd_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output fcd_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [10:0] cfg_data
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);

	logic [7:0] thr_q;
	logic [10:0] wid_q, hgt_q;
	logic [XW:0] wlim;
	logic [YW:0] hlim;
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic adv;

	// pipeline valid and stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [XW-1:0] x_s1, x_s2;
	logic [YW-1:0] y_s1, y_s2;
	logic [7:0] pix_s1;
	logic last_s1, last_s2;
	logic emit_s1, emit_s2;
	logic [7:0] win_q [7][7];
	logic [6*8-1:0] mem [MAX_WIDTH];
	logic [6*8-1:0] rd_s2;
	logic [7:0] pix_s2;

	assign cfg_ready = 1'b1;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= fcd_pkg::THRESH_RST;
			wid_q <= fcd_pkg::WIDTH_RST;
			hgt_q <= fcd_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				fcd_pkg::REG_THRESHOLD: thr_q <= cfg_data[7:0];
				fcd_pkg::REG_WIDTH: wid_q <= cfg_data;
				fcd_pkg::REG_HEIGHT: hgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (wid_q < 11'd7) wlim = (XW+1)'(7);
		else if (32'(wid_q) > MAX_WIDTH) wlim = (XW+1)'(MAX_WIDTH);
		else wlim = (XW+1)'(wid_q);
		if (hgt_q < 11'd7) hlim = (YW+1)'(7);
		else if (32'(hgt_q) > MAX_HEIGHT) hlim = (YW+1)'(MAX_HEIGHT);
		else hlim = (YW+1)'(hgt_q);
	end

	// stage 1: position
	logic [XW-1:0] cx;
	logic [YW-1:0] cy;
	logic xend, yend;
	always_comb begin
		cx = in_data.frame_start ? '0 : col_q;
		cy = in_data.frame_start ? '0 : row_q;
		if ({1'b0, cx} >= wlim) cx = '0;
		if ({1'b0, cy} >= hlim) cy = '0;
		xend = ({1'b0, cx} == wlim - 1'b1);
		yend = ({1'b0, cy} == hlim - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			if (in_valid) begin
				col_q <= xend ? '0 : cx + 1'b1;
				row_q <= xend ? (yend ? '0 : cy + 1'b1) : cy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= cx;
			y_s1 <= cy;
			pix_s1 <= in_data.pixel;
			last_s1 <= xend && yend;
			emit_s1 <= (32'(cx) >= 6) && (32'(cy) >= 6);
		end
	end

	// stage 2: registered line memory read; the shifted column is written back from the stage 2 registers
	logic [6*8-1:0] wr_d;
	assign wr_d = {pix_s2, rd_s2[6*8-1:8]};

	always_ff @(posedge clk) begin
		if (adv && v_s2) mem[x_s2] <= wr_d;
		if (adv && v_s1) begin
			// a frame restart can put two requests on one column back to back
			if (v_s2 && x_s2 == x_s1) rd_s2 <= wr_d;
			else rd_s2 <= mem[x_s1];
		end
		if (adv) begin
			pix_s2 <= pix_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			last_s2 <= last_s1;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	// stage 3: window shift and centre position
	logic [9:0] x_s3, y_s3;
	logic last_s3, emit_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 7; r++)
				for (int c = 0; c < 7; c++) win_q[r][c] <= 8'd0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			if (v_s2) begin
				for (int r = 0; r < 7; r++)
					for (int c = 0; c < 6; c++) win_q[r][c] <= win_q[r][c+1];
				for (int r = 0; r < 6; r++) win_q[r][6] <= rd_s2[r*8 +: 8];
				win_q[6][6] <= pix_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3 <= 10'(x_s2 - 3'd3);
			y_s3 <= 10'(y_s2 - 3'd3);
			last_s3 <= last_s2;
			emit_s3 <= emit_s2 && v_s2;
		end
	end

	// stage 4: class bits and absolute differences
	logic [fcd_pkg::NPTS-1:0] hi_s4, lo_s4;
	logic [7:0] ad_s4 [fcd_pkg::NPTS];
	logic [9:0] x_s4, y_s4;
	logic last_s4, emit_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < fcd_pkg::NPTS; i++) begin
				hi_s4[i] <= {1'b0, win_q[fcd_pkg::CROW[i]][fcd_pkg::CCOL[i]]} >
					{1'b0, win_q[3][3]} + {1'b0, thr_q};
				lo_s4[i] <= {1'b0, win_q[fcd_pkg::CROW[i]][fcd_pkg::CCOL[i]]} + {1'b0, thr_q} <
					{1'b0, win_q[3][3]};
				ad_s4[i] <= (win_q[fcd_pkg::CROW[i]][fcd_pkg::CCOL[i]] > win_q[3][3]) ?
					win_q[fcd_pkg::CROW[i]][fcd_pkg::CCOL[i]] - win_q[3][3] :
					win_q[3][3] - win_q[fcd_pkg::CROW[i]][fcd_pkg::CCOL[i]];
			end
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			last_s4 <= last_s3;
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	// stage 5: arc test, compass test, score sum
	function automatic logic arc9(input logic [15:0] m);
		logic [31:0] d;
		logic f;
		d = {m, m};
		f = 1'b0;
		for (int s = 0; s < fcd_pkg::NPTS; s++)
			if (&d[s +: fcd_pkg::ARC]) f = 1'b1;
		return f;
	endfunction

	logic hs_ok, seg_ok;
	logic [11:0] sum;
	logic [8:0] sum_a [8];
	logic [9:0] sum_b [4];
	logic [10:0] sum_c [2];
	always_comb begin
		hs_ok = ($countones({hi_s4[0], hi_s4[4], hi_s4[8], hi_s4[12]}) >= 3) ||
			($countones({lo_s4[0], lo_s4[4], lo_s4[8], lo_s4[12]}) >= 3);
		seg_ok = arc9(hi_s4) || arc9(lo_s4);
		// four-level adder tree
		for (int i = 0; i < 8; i++) sum_a[i] = {1'b0, ad_s4[2*i]} + {1'b0, ad_s4[2*i+1]};
		for (int i = 0; i < 4; i++) sum_b[i] = {1'b0, sum_a[2*i]} + {1'b0, sum_a[2*i+1]};
		for (int i = 0; i < 2; i++) sum_c[i] = {1'b0, sum_b[2*i]} + {1'b0, sum_b[2*i+1]};
		sum = {1'b0, sum_c[0]} + {1'b0, sum_c[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4 && emit_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.center_x <= x_s4;
			out_data.center_y <= y_s4;
			out_data.corner <= hs_ok && seg_ok;
			out_data.score <= (hs_ok && seg_ok) ? sum : 12'd0;
			out_data.frame_last <= last_s4;
		end
	end

	assign out_valid = v_s5;

	`ASSERT_NEVER(a_no_bad_emit, clk, arst_n, v_s5 && !out_data.corner && out_data.score != 12'd0)
	`ASSERT_IMPL(a_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
	`ASSERT_IMPL(a_emit_valid, clk, arst_n, (adv && v_s4 && emit_s4) |=> out_valid)
endmodule
